[src/mlenc_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-mode line encoder package
// Shared types and constants for the line encoder core: line modes, register
// indexes, symbol codes and the level step.
// ----------------------------------------------------------------------------
package mlenc_pkg;

   // Configuration register indexes
   typedef enum logic {
      REG_LINE_MODE   = 1'b0,
      REG_AXIS_OFFSET = 1'b1
   } reg_index_type;

   // Line modes; the two spare codes behave as NRZ-L
   typedef enum logic [2:0] {
      MODE_NRZ_L        = 3'd0,
      MODE_NRZ_I        = 3'd1,
      MODE_MANCHESTER   = 3'd2,
      MODE_DIFF_MANCH   = 3'd3,
      MODE_AMI          = 3'd4,
      MODE_PSEUDO_TERN  = 3'd5
   } line_mode_type;

   // Symbol code held in the serialiser: level relative to the axis
   typedef enum logic [1:0] {
      SYM_ZERO = 2'd0,
      SYM_POS  = 2'd1,
      SYM_NEG  = 2'd2
   } symbol_type;

   localparam int unsigned BYTE_BITS   = 8;
   localparam int unsigned MAX_SYMBOLS = 2 * BYTE_BITS;
   localparam int unsigned COUNT_W     = $clog2(MAX_SYMBOLS + 1);

   localparam int unsigned MODE_W   = 3;
   localparam int unsigned OFFSET_W = 11;
   localparam int unsigned LEVEL_W  = 12;
   localparam int unsigned CSR_W    = OFFSET_W;

   localparam logic signed [LEVEL_W-1:0] LEVEL_STEP = 12'sd50;

endpackage

[src/multi_mode_line_encoder_core.sv]
// Each accepted byte is encoded into the symbol buffer; its symbols then move
// into the output register, one symbol per cycle while the output is not
// stalled. A byte gives 8 symbols (16 in the Manchester modes); the next byte
// is taken as the last symbol of the current one is loaded. Synchronous
// active-high reset clears the configuration and all valid flags and sets the
// line state to its start-of-message values.
// ----------------------------------------------------------------------------
// Multi-mode line encoder core
// Serialises bytes MSB first into signed line levels around a configurable
// axis under NRZ-L, NRZ-I, Manchester, differential Manchester, AMI and
// pseudoternary coding.
// ----------------------------------------------------------------------------
module multi_mode_line_encoder_core
   import mlenc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [CSR_W-1:0]           csr_write_data,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_BITS-1:0]       req_data_byte,
   input  logic                       req_start_of_message,
   input  logic                       req_end_of_message,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [LEVEL_W-1:0]  rsp_line_level,
   output logic                       rsp_byte_done,
   output logic                       rsp_message_done
);

   // Configuration
   logic [MODE_W-1:0]          line_mode_ff;
   logic signed [OFFSET_W-1:0] axis_offset_ff;

   // Line state
   logic nrzi_high_ff, nrzi_high_in;
   logic diff_phase_ff, diff_phase_in;
   logic ami_neg_ff, ami_neg_in;
   logic pseudo_neg_ff, pseudo_neg_in;

   // Symbol serialiser
   symbol_type           sym_ff [MAX_SYMBOLS];
   symbol_type           sym_in [MAX_SYMBOLS];
   symbol_type           new_sym [MAX_SYMBOLS];
   logic [COUNT_W-1:0]   cnt_ff, cnt_in, new_cnt;
   logic                 eom_ff;

   // Output register
   logic                      rsp_valid_ff;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic                      byte_done_ff, byte_done_in;
   logic                      msg_done_ff;

   logic accept;
   logic advance;

   assign advance   = (cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == COUNT_W'(1)) && advance);
   assign accept    = req_valid && req_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_mode_ff   <= '0;
         axis_offset_ff <= '0;
      end else if (csr_write_en) begin
         unique case (reg_index_type'(csr_index))
            REG_LINE_MODE:   line_mode_ff   <= csr_write_data[MODE_W-1:0];
            REG_AXIS_OFFSET: axis_offset_ff <= signed'(csr_write_data[OFFSET_W-1:0]);
            default:         line_mode_ff   <= line_mode_ff;
         endcase
      end
   end

   // Encode a whole byte into its symbol sequence. The state bits are running
   // parities over the byte, so the chain is eight single-bit steps deep.
   always_comb begin
      logic nrzi, phase, ami, pseudo, bit_v, twice;
      nrzi   = req_start_of_message ? 1'b1 : nrzi_high_ff;
      phase  = req_start_of_message ? 1'b0 : diff_phase_ff;
      ami    = req_start_of_message ? 1'b1 : ami_neg_ff;
      pseudo = req_start_of_message ? 1'b1 : pseudo_neg_ff;
      twice  = (line_mode_ff == MODE_MANCHESTER) || (line_mode_ff == MODE_DIFF_MANCH);
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         new_sym[k] = SYM_ZERO;
      end
      for (int i = 0; i < BYTE_BITS; i++) begin
         bit_v = req_data_byte[BYTE_BITS-1-i];
         unique case (line_mode_ff)
            MODE_NRZ_I: begin
               nrzi       = nrzi ^ bit_v;
               new_sym[i] = nrzi ? SYM_POS : SYM_NEG;
            end
            MODE_MANCHESTER: begin
               new_sym[2*i]   = bit_v ? SYM_NEG : SYM_POS;
               new_sym[2*i+1] = bit_v ? SYM_POS : SYM_NEG;
            end
            MODE_DIFF_MANCH: begin
               phase          = phase ^ bit_v;
               new_sym[2*i]   = phase ? SYM_NEG : SYM_POS;
               new_sym[2*i+1] = phase ? SYM_POS : SYM_NEG;
            end
            MODE_AMI: begin
               if (bit_v) begin
                  ami        = ~ami;
                  new_sym[i] = ami ? SYM_NEG : SYM_POS;
               end
            end
            MODE_PSEUDO_TERN: begin
               if (!bit_v) begin
                  pseudo     = ~pseudo;
                  new_sym[i] = pseudo ? SYM_NEG : SYM_POS;
               end
            end
            default: begin
               new_sym[i] = bit_v ? SYM_POS : SYM_NEG;
            end
         endcase
      end
      new_cnt       = twice ? COUNT_W'(MAX_SYMBOLS) : COUNT_W'(BYTE_BITS);
      nrzi_high_in  = accept ? nrzi   : nrzi_high_ff;
      diff_phase_in = accept ? phase  : diff_phase_ff;
      ami_neg_in    = accept ? ami    : ami_neg_ff;
      pseudo_neg_in = accept ? pseudo : pseudo_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrzi_high_ff  <= 1'b1;
         diff_phase_ff <= 1'b0;
         ami_neg_ff    <= 1'b1;
         pseudo_neg_ff <= 1'b1;
      end else begin
         nrzi_high_ff  <= nrzi_high_in;
         diff_phase_ff <= diff_phase_in;
         ami_neg_ff    <= ami_neg_in;
         pseudo_neg_ff <= pseudo_neg_in;
      end
   end

   // Serialiser: a new byte replaces the buffer, otherwise it shifts down by
   // one symbol each time the output register is loaded.
   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         if (accept) begin
            sym_in[k] = new_sym[k];
         end else if (advance && (k < MAX_SYMBOLS - 1)) begin
            sym_in[k] = sym_ff[k+1];
         end else begin
            sym_in[k] = sym_ff[k];
         end
      end
      if (accept) begin
         cnt_in = new_cnt;
      end else if (advance) begin
         cnt_in = cnt_ff - COUNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      if (accept) begin
         eom_ff <= req_end_of_message;
      end
   end

   // Output level from the head symbol
   always_comb begin
      logic signed [LEVEL_W-1:0] base;
      base = LEVEL_W'(axis_offset_ff);
      unique case (sym_ff[0])
         SYM_POS: level_in = base + LEVEL_STEP;
         SYM_NEG: level_in = base - LEVEL_STEP;
         default: level_in = base;
      endcase
      byte_done_in = (cnt_ff == COUNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff     <= level_in;
         byte_done_ff <= byte_done_in;
         msg_done_ff  <= byte_done_in && eom_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_level   = level_ff;
   assign rsp_byte_done    = byte_done_ff;
   assign rsp_message_done = msg_done_ff;

endmodule

[tb/tb_multi_mode_line_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-mode line encoder core testbench
// Sends message bytes with random gaps and random back-pressure. A local
// encoder works out every line symbol that each byte should give. Each symbol
// the core returns is checked field by field, in order. Covers all eight mode
// codes, offsets at both ends of the register and mode changes inside a message.
// ----------------------------------------------------------------------------
module tb_multi_mode_line_encoder_core;
   import mlenc_pkg::*;

   localparam int BYTE_TARGET  = 430;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic                      byte_done;
      logic                      message_done;
   } line_symbol_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_en = 1'b0;
   logic                       csr_index = 1'b0;
   logic [CSR_W-1:0]           csr_write_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [BYTE_BITS-1:0]       req_data_byte = '0;
   logic                       req_start_of_message = 1'b0;
   logic                       req_end_of_message = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [LEVEL_W-1:0]  rsp_line_level;
   logic                       rsp_byte_done;
   logic                       rsp_message_done;

   // Local copy of the encoder's configuration and line state
   logic [MODE_W-1:0]          coder_mode = MODE_NRZ_L;
   logic signed [OFFSET_W-1:0] coder_offset = '0;
   logic                       nrzi_high = 1'b1;
   logic                       diff_phase = 1'b0;
   logic                       ami_negative = 1'b1;
   logic                       pseudo_negative = 1'b1;

   line_symbol_type expected_symbols[$];

   int   error_count = 0;
   int   bytes_sent = 0;
   int   symbols_checked = 0;
   int   settings_used = 0;
   int   stall_cycles = 0;
   logic [7:0] modes_seen = '0;
   bit   no_idle = 1'b0;

   multi_mode_line_encoder_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_start_of_message (req_start_of_message),
      .req_end_of_message   (req_end_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_line_level       (rsp_line_level),
      .rsp_byte_done        (rsp_byte_done),
      .rsp_message_done     (rsp_message_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 27);
   end

   // Encodes one byte MSB first and queues the symbols it should produce.
   function automatic void encode_byte(logic [7:0] data, logic som, logic eom);
      logic                      twice;
      logic                      bit_value;
      logic                      last;
      logic signed [LEVEL_W-1:0] axis;
      logic signed [LEVEL_W-1:0] first_half;
      logic signed [LEVEL_W-1:0] second_half;
      line_symbol_type           sym;
      if (som) begin
         nrzi_high       = 1'b1;
         diff_phase      = 1'b0;
         ami_negative    = 1'b1;
         pseudo_negative = 1'b1;
      end
      twice = (coder_mode == MODE_MANCHESTER) || (coder_mode == MODE_DIFF_MANCH);
      axis  = LEVEL_W'(coder_offset);
      for (int i = 7; i >= 0; i--) begin
         bit_value  = data[i];
         last       = (i == 0);
         first_half = '0;
         case (coder_mode)
            MODE_NRZ_I: begin
               if (bit_value) nrzi_high = ~nrzi_high;
               first_half = nrzi_high ? LEVEL_STEP : -LEVEL_STEP;
            end
            MODE_MANCHESTER: begin
               first_half = bit_value ? -LEVEL_STEP : LEVEL_STEP;
            end
            MODE_DIFF_MANCH: begin
               if (bit_value) diff_phase = ~diff_phase;
               first_half = diff_phase ? -LEVEL_STEP : LEVEL_STEP;
            end
            MODE_AMI: begin
               if (bit_value) begin
                  ami_negative = ~ami_negative;
                  first_half = ami_negative ? -LEVEL_STEP : LEVEL_STEP;
               end
            end
            MODE_PSEUDO_TERN: begin
               if (!bit_value) begin
                  pseudo_negative = ~pseudo_negative;
                  first_half = pseudo_negative ? -LEVEL_STEP : LEVEL_STEP;
               end
            end
            default: begin
               first_half = bit_value ? LEVEL_STEP : -LEVEL_STEP;
            end
         endcase
         second_half = -first_half;
         if (twice) begin
            sym = '{axis + first_half, 1'b0, 1'b0};
            expected_symbols.push_back(sym);
            sym = '{axis + second_half, last, last && eom};
         end else begin
            sym = '{axis + first_half, last, last && eom};
         end
         expected_symbols.push_back(sym);
      end
   endfunction

   // Result checker: every symbol transaction is matched against the oldest
   // expected symbol.
   always @(posedge clock) begin
      line_symbol_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         symbols_checked++;
         if (expected_symbols.size() == 0) begin
            $error("Symbol returned with none expected: level %0d", rsp_line_level);
            error_count++;
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_line_level !== want.level) begin
               $error("line_level mismatch: expected %0d, actual %0d",
                      want.level, rsp_line_level);
               error_count++;
            end
            if (rsp_byte_done !== want.byte_done) begin
               $error("byte_done mismatch: expected %0b, actual %0b",
                      want.byte_done, rsp_byte_done);
               error_count++;
            end
            if (rsp_message_done !== want.message_done) begin
               $error("message_done mismatch: expected %0b, actual %0b",
                      want.message_done, rsp_message_done);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_byte(logic [7:0] data, logic som, logic eom);
      @(negedge clock);
      if (!no_idle) begin
         while ($urandom_range(99) < 27) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid            <= 1'b1;
      req_data_byte        <= data;
      req_start_of_message <= som;
      req_end_of_message   <= eom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_byte(data, som, eom);
      bytes_sent++;
   endtask

   // Stops sending and waits until every expected symbol has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      if (idx == REG_LINE_MODE) begin
         coder_mode = value[MODE_W-1:0];
         modes_seen[value[MODE_W-1:0]] = 1'b1;
      end else begin
         coder_offset = value;
      end
   endtask

   task automatic set_mode(logic [MODE_W-1:0] mode);
      logic [CSR_W-1:0] value;
      // Upper bits of the write data are don't-care for the mode register.
      value = {8'($urandom), mode};
      write_reg(REG_LINE_MODE, value);
   endtask

   task automatic configure(logic [MODE_W-1:0] mode, logic signed [OFFSET_W-1:0] offset);
      wait_idle();
      set_mode(mode);
      write_reg(REG_AXIS_OFFSET, offset);
      settings_used++;
   endtask

   task automatic test_reset_defaults();
      modes_seen[MODE_NRZ_L] = 1'b1;
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
   endtask

   // The two spare mode codes are expected to behave as NRZ-L.
   task automatic test_each_mode();
      logic signed [OFFSET_W-1:0] offsets [4];
      offsets = '{11'h400, 11'sd1023, -11'sd1000, 11'sd1000};
      for (int m = 0; m < 8; m++) begin
         configure(m[MODE_W-1:0], offsets[m % 4]);
         send_byte(8'hA5, 1'b1, 1'b0);
         send_byte(8'h3C, 1'b0, 1'b1);
      end
   endtask

   // Each mode should touch only its own state bit, so the NRZ-I level must
   // carry on across the AMI byte in the middle.
   task automatic test_mode_change_in_message();
      configure(MODE_NRZ_I, 11'sd0);
      send_byte(8'hB4, 1'b1, 1'b0);
      wait_idle();
      set_mode(MODE_AMI);
      send_byte(8'h6D, 1'b0, 1'b0);
      wait_idle();
      set_mode(MODE_NRZ_I);
      send_byte(8'h5A, 1'b0, 1'b0);
      wait_idle();
      set_mode(MODE_DIFF_MANCH);
      send_byte(8'hC3, 1'b0, 1'b1);
   endtask

   task automatic test_random_messages();
      int                         len;
      bit                         well_formed;
      logic                       som;
      logic                       eom;
      logic [7:0]                 data;
      logic signed [OFFSET_W-1:0] offset;
      while (bytes_sent < BYTE_TARGET) begin
         // One stretch of the run goes without any idling on either side, so
         // the register settings are left alone throughout it.
         no_idle = (bytes_sent >= 200) && (bytes_sent < 280);
         if (!no_idle && ($urandom_range(1) == 1)) begin
            case ($urandom_range(7))
               0:       offset = 11'h400;
               1:       offset = 11'sd1023;
               2:       offset = -11'sd1000;
               3:       offset = 11'sd1000;
               default: offset = 11'($urandom_range(2047));
            endcase
            configure(3'($urandom_range(7)), offset);
         end
         len = $urandom_range(1, 10);
         well_formed = ($urandom_range(99) < 85);
         for (int k = 0; k < len; k++) begin
            if (!no_idle && k > 0 && $urandom_range(11) == 0) begin
               wait_idle();
               set_mode(3'($urandom_range(7)));
            end
            case ($urandom_range(7))
               0:       data = 8'h00;
               1:       data = 8'hFF;
               default: data = 8'($urandom);
            endcase
            if (well_formed) begin
               som = (k == 0);
               eom = (k == len - 1);
            end else begin
               som = 1'($urandom_range(1));
               eom = 1'($urandom_range(1));
            end
            send_byte(data, som, eom);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_each_mode();
      test_mode_change_in_message();
      test_random_messages();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes, checked %0d line symbols over %0d register settings.",
               bytes_sent, symbols_checked, settings_used);
      $display("Mode codes exercised (bit per code): %b", modes_seen);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
src/mlenc_pkg.sv
src/multi_mode_line_encoder_core.sv
tb/tb_multi_mode_line_encoder_core.sv
